// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file cd_checker.
// Each macro samples on the rising edge of aclk and is off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cd_pkg.sv =====
// ----------------------------------------------------------------------------
// cd_pkg
// Types and constants shared by the circular deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cd_pkg;

    localparam int DEPTH  = 16;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 5;
    localparam int MODE_W = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_FULL         = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IN_RESTRICT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUT_RESTRICT = 2'd2;

    localparam logic [ADDR_W-1:0] REG_RESTRICT_MODE = 3'd0;

    typedef enum logic [1:0] {
        FUNC_INS_RIGHT = 2'd0,
        FUNC_INS_LEFT  = 2'd1,
        FUNC_DEL_LEFT  = 2'd2,
        FUNC_DEL_RIGHT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FORBIDDEN = 2'd3
    } status_t;

    typedef struct packed {
        func_t                   func;
        logic signed [VAL_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] removed_value;
        logic [CNT_W-1:0]        occupancy;
    } out_beat_t;

    // One-hot per committed operation, broadcast along the cell row
    typedef struct packed {
        logic ins_left;
        logic ins_right;
        logic del_left;
        logic del_right;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/cd_cell.sv =====
// ----------------------------------------------------------------------------
// cd_cell
// One slot of the deque row: holds a value and an occupied flag, shifts with
// its neighbors on left-end operations and fills or drains at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cd_pkg::cell_ctl_t          ctl,
    input  wire logic [cd_pkg::VAL_W-1:0]   ins_value,
    input  wire logic [cd_pkg::VAL_W-1:0]   left_data,
    input  wire logic                       left_valid,
    input  wire logic [cd_pkg::VAL_W-1:0]   right_data,
    input  wire logic                       right_valid,
    output logic [cd_pkg::VAL_W-1:0]        data,
    output logic                            valid,
    output logic                            tail
);
    import cd_pkg::*;

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic             valid_reg;
    logic             valid_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctl.ins_left) begin
            // shift one slot toward the right end
            data_next  = left_data;
            valid_next = left_valid;
        end else if (ctl.del_left) begin
            data_next  = right_data;
            valid_next = right_valid;
        end else if (ctl.ins_right) begin
            // first free slot takes the value
            if (!valid_reg && left_valid) begin
                data_next  = ins_value;
                valid_next = 1'b1;
            end
        end else if (ctl.del_right) begin
            if (valid_reg && !right_valid) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign tail  = valid_reg && !right_valid;

endmodule

`default_nettype wire

// ===== src/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit values with a mode register that can
// forbid left inserts or right deletes.
// ----------------------------------------------------------------------------
// The deque accepts one operation per clock cycle while its output register is
// free or drains in that cycle, and presents the result from that register in
// the cycle after acceptance; a new operation is taken while that result waits,
// as long as the register frees in the same cycle. The row of DEPTH cells, each
// holding one entry in left-to-right order, shifts or fills as an operation is
// accepted. No clearing pass is needed after reset. restrict_mode (byte address
// 0) selects full, input-restricted (no left insert) or output-restricted (no
// right delete) behavior and may be written only while the block is idle.
`default_nettype none

module circular_deque (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire cd_pkg::in_beat_t            s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output cd_pkg::out_beat_t                m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [cd_pkg::DATA_W-1:0]   pwdata,
    output logic [cd_pkg::DATA_W-1:0]        prdata,
    output logic                             pready
);
    import cd_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;
    out_beat_t         m_data_next;

    logic [VAL_W-1:0]  cell_data  [DEPTH];
    logic              cell_valid [DEPTH];
    logic              cell_tail  [DEPTH];
    cell_ctl_t         ctl;

    logic              accept;
    logic              full;
    logic              empty;
    logic              forbidden;
    logic              is_insert;
    logic [VAL_W-1:0]  tail_value;

    assign pready  = 1'b1;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = cell_valid[DEPTH-1];
    assign empty   = !cell_valid[0];

    always_comb begin
        prdata = '0;
        if (paddr == REG_RESTRICT_MODE) begin
            prdata[MODE_W-1:0] = mode_reg;
        end
    end

    always_comb begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_tail[i]) begin
                tail_value = tail_value | cell_data[i];
            end
        end
    end

    always_comb begin
        forbidden = (mode_reg == MODE_IN_RESTRICT  && s_data.func == FUNC_INS_LEFT) ||
                    (mode_reg == MODE_OUT_RESTRICT && s_data.func == FUNC_DEL_RIGHT);
        is_insert = (s_data.func == FUNC_INS_RIGHT) || (s_data.func == FUNC_INS_LEFT);

        m_data_next               = '0;
        m_data_next.status        = ST_OK;
        m_data_next.removed_value = '0;
        ctl                       = '0;
        count_next                = count_reg;

        if (forbidden) begin
            m_data_next.status = ST_FORBIDDEN;
        end else if (is_insert) begin
            if (full) begin
                m_data_next.status = ST_OVERFLOW;
            end else begin
                ctl.ins_right = accept && (s_data.func == FUNC_INS_RIGHT);
                ctl.ins_left  = accept && (s_data.func == FUNC_INS_LEFT);
                count_next    = count_reg + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                m_data_next.status = ST_UNDERFLOW;
            end else begin
                ctl.del_left  = accept && (s_data.func == FUNC_DEL_LEFT);
                ctl.del_right = accept && (s_data.func == FUNC_DEL_RIGHT);
                count_next    = count_reg - CNT_W'(1);
                m_data_next.removed_value = (s_data.func == FUNC_DEL_LEFT) ?
                                            cell_data[0] : tail_value;
            end
        end
        m_data_next.occupancy = count_next;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VAL_W-1:0] left_data;
        logic             left_valid;
        logic [VAL_W-1:0] right_data;
        logic             right_valid;

        if (i == 0) begin : g_head
            assign left_data  = s_data.value;
            assign left_valid = 1'b1;
        end else begin : g_mid_l
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == DEPTH-1) begin : g_end
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid_r
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        cd_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .ins_value   (s_data.value),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tail        (cell_tail[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_FULL;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && (paddr == REG_RESTRICT_MODE)) begin
                mode_reg <= pwdata[MODE_W-1:0];
            end
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== src/cd_checker.sv =====
// ----------------------------------------------------------------------------
// cd_checker
// Port-level checks on the circular deque result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cd_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire cd_pkg::out_beat_t           m_data
);
    import cd_pkg::*;

    logic s_beat;
    assign s_beat = s_valid && s_ready;

    // a stalled result beat holds
    `CD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // overflow only with a full store, underflow only with an empty one
    `CD_ASSERT_NOW(a_ovf_full, m_valid && m_data.status == ST_OVERFLOW, m_data.occupancy == CNT_W'(DEPTH), "overflow reported below full")
    `CD_ASSERT_NOW(a_unf_empty, m_valid && m_data.status == ST_UNDERFLOW, m_data.occupancy == '0, "underflow reported while holding entries")

    // failed operations return zero
    `CD_ASSERT_NOW(a_fail_zero, m_valid && m_data.status != ST_OK, m_data.removed_value == '0, "nonzero value on failed operation")

    // a beat accepted with the result side free appears next cycle
    `CD_ASSERT_NEXT(a_beat_out, s_beat, m_valid, "accepted beat produced no result")

endmodule

bind circular_deque cd_checker u_cd_checker (.*);

`default_nettype wire
